/* rtl/core/sfr_pkg.sv */
// shared types and constants for the stepper frequency ramp core
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps

package sfr_pkg;

  // configuration port
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_CLOCK_HZ  = 2'd0;
  localparam logic [1:0] REG_PRESCALER = 2'd1;
  localparam logic [1:0] REG_STEP_HZ   = 2'd2;
  localparam logic [15:0] STEP_HZ_RESET = 16'd100;

  // command opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // ramp phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;
  localparam logic [1:0] PH_DECEL = 2'd3;

  // hold_ms / 5 as (hold_ms * 52429) >> 18, exact for 16-bit inputs
  localparam logic [15:0] TICK_RECIP = 16'd52429;
  localparam int          TICK_SHIFT = 18;

  // divider geometry
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 33;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] from_freq;
    logic [15:0] to_freq;
    logic [15:0] hold_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pulse_freq;
    logic [15:0] reload_value;
    logic [14:0] compare_value;
    logic        reload_written;
    logic        pwm_on;
    logic [1:0]  ramp_phase;
  } res_t;

  typedef struct packed {
    logic [31:0] clock_hz;
    logic [15:0] prescaler;
    logic [15:0] step_hz;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/sfr_cfg_regs.sv */
// apb-style configuration registers: timer clock, prescaler, ramp step
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output sfr_pkg::cfg_t              cfg
);
  import sfr_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_hz  <= '0;
      cfg.prescaler <= '0;
      cfg.step_hz   <= STEP_HZ_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_CLOCK_HZ:  cfg.clock_hz  <= pwdata;
        REG_PRESCALER: cfg.prescaler <= pwdata[15:0];
        REG_STEP_HZ:   cfg.step_hz   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CLOCK_HZ:  prdata = cfg.clock_hz;
      REG_PRESCALER: prdata = {16'd0, cfg.prescaler};
      REG_STEP_HZ:   prdata = {16'd0, cfg.step_hz};
      default:       prdata = '0;
    endcase
  end

endmodule

/* rtl/core/sfr_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on sfr_pkg
`timescale 1ns / 1ps

module sfr_divider (
  input  logic              clk,
  input  logic              rst,
  input  sfr_pkg::div_req_t req,
  output sfr_pkg::div_rsp_t rsp
);
  import sfr_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  // shift in the next dividend bit and trial-subtract
  assign rem_sh  = {rem, quo[DIVIDEND_W-1]};
  assign fits    = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den <= req.divisor;
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.quotient = quo;

endmodule

/* rtl/core/stepper_frequency_ramp_core.sv */
// top level of the stepper frequency ramp: command sequencer and ramp state
// depends on sfr_pkg, sfr_cfg_regs, sfr_divider
`timescale 1ns / 1ps

// usage
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one command item: tick,
//   start or stop. res channel (res_valid/res_ready/res) returns exactly one
//   result item per command: applied frequency, timer reload/compare, a
//   rewrite flag, pwm enable and ramp phase.
//   the apb port holds timer clock (0x0), prescaler (0x4) and ramp step (0x8);
//   write it only while no command is in flight.
// sequencing
//   a command that rewrites the timer (a tick in accelerate or decelerate
//   with a nonzero new frequency) runs exec, multiply, divider launch, one
//   32-bit by 33-bit division on the restoring divider at one quotient bit
//   per cycle, writeback and result handoff. every other command goes from
//   exec straight to result handoff. cmd_ready is high only while the
//   sequencer is idle: a new command waits until the last result is loaded.
// reset
//   rst is synchronous: ramp idle, frequency, reload and compare zero,
//   pwm off, ramp step back to 100 Hz, no result pending.
// stalls
//   the result sits in an output register. a new command is accepted while
//   it waits; the next result is held back until res_ready takes the old one

module stepper_frequency_ramp_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  sfr_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output sfr_pkg::res_t              res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sfr_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a command
  localparam logic [2:0] ST_EXEC  = 3'd1;  // update ramp state
  localparam logic [2:0] ST_MUL   = 3'd2;  // divisor = (psc+1) * freq
  localparam logic [2:0] ST_DSTRT = 3'd3;  // launch divider
  localparam logic [2:0] ST_DIV   = 3'd4;  // wait for quotient
  localparam logic [2:0] ST_WB    = 3'd5;  // write reload and compare
  localparam logic [2:0] ST_DONE  = 3'd6;  // hand result to output register

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0] st;
  cmd_t       cmd_q;

  // ramp state
  logic [1:0]  phase;
  logic [15:0] ramp_freq;
  logic [15:0] goal_freq;
  logic [13:0] hold_length;
  logic [13:0] hold_left;
  logic [15:0] applied_freq;
  logic [15:0] reload_reg;
  logic [14:0] compare_reg;
  logic        output_enabled;
  logic        wrote;

  logic [DIVISOR_W-1:0] div_den;

  // combinational helpers for the exec, multiply and writeback steps
  logic [16:0] accel_sum;
  logic        accel_hit;
  logic [15:0] decel_diff;
  logic        decel_more;
  logic [31:0] hold_prod;
  logic [16:0] psc_inc;
  logic [15:0] quo_dec;
  logic [15:0] reload_new;
  logic        res_load;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  sfr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pready    = 1'b1;
  assign cmd_ready = (st == ST_IDLE);

  // result register takes a new item when empty or drained this cycle
  assign res_load  = (st == ST_DONE) && (!res_valid || res_ready);

  // the divider sees timer_clock / ((psc+1) * f), same floor as two divisions
  assign div_req.start    = (st == ST_DSTRT);
  assign div_req.dividend = cfg.clock_hz;
  assign div_req.divisor  = div_den;

  assign accel_sum  = {1'b0, ramp_freq} + {1'b0, cfg.step_hz};
  assign accel_hit  = accel_sum >= {1'b0, goal_freq};
  assign decel_more = ramp_freq > cfg.step_hz;
  assign decel_diff = ramp_freq - cfg.step_hz;
  assign hold_prod  = 32'(cmd_q.hold_ms) * 32'(TICK_RECIP);
  assign psc_inc    = {1'b0, cfg.prescaler} + 17'd1;

  // reload = quotient - 1 modulo 2^16, never below 1; zero timer clock forces 1
  assign quo_dec    = div_rsp.quotient[15:0] - 16'd1;
  assign reload_new = (cfg.clock_hz == '0 || quo_dec == '0) ? 16'd1 : quo_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      phase          <= PH_IDLE;
      ramp_freq      <= '0;
      goal_freq      <= '0;
      hold_length    <= '0;
      hold_left      <= '0;
      applied_freq   <= '0;
      reload_reg     <= '0;
      compare_reg    <= '0;
      output_enabled <= 1'b0;
      wrote          <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (cmd_valid) begin
            st <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          wrote <= 1'b0;
          st    <= ST_DONE;
          case (cmd_q.opcode)
            OP_START: begin
              ramp_freq   <= cmd_q.from_freq;
              goal_freq   <= cmd_q.to_freq;
              hold_length <= hold_prod[31:TICK_SHIFT];
              hold_left   <= '0;
              if (cmd_q.to_freq == '0 && cmd_q.from_freq == '0) begin
                phase <= PH_IDLE;
              end else begin
                output_enabled <= 1'b1;
                if (cmd_q.to_freq > cmd_q.from_freq) begin
                  phase <= PH_ACCEL;
                end else if (cmd_q.to_freq < cmd_q.from_freq) begin
                  phase <= PH_DECEL;
                end else begin
                  phase <= PH_HOLD;
                end
              end
            end
            OP_STOP: begin
              output_enabled <= 1'b0;
              applied_freq   <= '0;
              phase          <= PH_IDLE;
              ramp_freq      <= '0;
              goal_freq      <= '0;
              hold_left      <= '0;
            end
            OP_TICK: begin
              case (phase)
                PH_ACCEL: begin
                  if (accel_hit) begin
                    ramp_freq <= goal_freq;
                    if (hold_length != '0) begin
                      phase     <= PH_HOLD;
                      hold_left <= hold_length;
                    end
                    if (goal_freq != '0) begin
                      st <= ST_MUL;
                    end
                  end else begin
                    ramp_freq <= accel_sum[15:0];
                    if (accel_sum[15:0] != '0) begin
                      st <= ST_MUL;
                    end
                  end
                end
                PH_HOLD: begin
                  if (hold_left != '0) begin
                    hold_left <= hold_left - 14'd1;
                    if (hold_left == 14'd1) begin
                      phase <= PH_DECEL;
                    end
                  end
                end
                PH_DECEL: begin
                  if (decel_more) begin
                    ramp_freq <= decel_diff;
                    st        <= ST_MUL;
                  end else begin
                    // step would take the ramp to zero or below: ramp to zero, pulse output off
                    ramp_freq      <= '0;
                    phase          <= PH_IDLE;
                    output_enabled <= 1'b0;
                    applied_freq   <= '0;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        ST_MUL: begin
          div_den <= DIVISOR_W'(psc_inc) * DIVISOR_W'(ramp_freq);
          st      <= ST_DSTRT;
        end
        ST_DSTRT: begin
          st <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            st <= ST_WB;
          end
        end
        ST_WB: begin
          reload_reg   <= reload_new;
          compare_reg  <= reload_new[15:1];
          applied_freq <= ramp_freq;
          wrote        <= 1'b1;
          st           <= ST_DONE;
        end
        ST_DONE: begin
          if (res_load) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // command capture and result register
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && cmd_valid) begin
      cmd_q <= cmd;
    end
    if (res_load) begin
      res.pulse_freq     <= applied_freq;
      res.reload_value   <= reload_reg;
      res.compare_value  <= compare_reg;
      res.reload_written <= wrote;
      res.pwm_on         <= output_enabled;
      res.ramp_phase     <= phase;
    end
  end

  // a disabled output never reports a frequency
  a_off_no_freq: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.pwm_on || res.pulse_freq == '0))
    else $error("pwm off with nonzero pulse frequency");

  // a rewritten timer never holds a zero reload
  a_reload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.reload_written) |-> (res.reload_value != '0))
    else $error("reload written as zero");

  // compare always tracks half the reload
  a_compare_half: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.compare_value == res.reload_value[15:1]))
    else $error("compare not half of reload");

  // quotient arrives only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (st == ST_DIV))
    else $error("divider finished outside wait state");

endmodule
